@@ src/cfd_pkg.sv @@
`timescale 1ns / 1ps

package cfd_pkg;

	// One decoded word as it leaves the decode step.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ok;
	} cfd_result_t;

endpackage

@@ src/cobs_frame_decoder.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    data_byte, last_byte
// out       output     out_valid / out_ready  out_byte, out_last, frame_ok
// cfg       input      cfg_valid / cfg_ready  cfg_delimiter
//
// A word is held in the input register and decoded into the result register, from
// which its result is offered. One word is accepted per cycle unless the output
// stalls; the decode step is a compare and an add.
// Reset clears the frame state and sets the delimiter to zero.
// A stalled output holds the result and back-pressures the input register.
module cobs_frame_decoder import cfd_pkg::*; #(
	parameter int MAX_FRAME_LEN = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       frame_ok,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_delimiter
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        valid_s2;
	cfd_result_t result_s2;
	cfd_result_t result;
	logic [7:0]  delimiter_q;
	logic        advance;
	logic        step;

	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign step      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	// Delimiter register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= 8'd0;
		end else if (cfg_valid) begin
			delimiter_q <= cfg_delimiter;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	cfd_step #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.data_in  (byte_s1),
		.last_in  (last_s1),
		.delimiter(delimiter_q),
		.result   (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_byte  = result_s2.data;
	assign out_last  = result_s2.last;
	assign frame_ok  = result_s2.ok;

	// A good-frame flag only ever rides on the last word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.ok) |-> result_s2.last)
		else $error("frame_ok without out_last");

	// A word held in the input register is not lost while the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("input register changed while stalled");

	// A decoded word always lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("decoded word dropped");

endmodule

@@ src/cfd_step.sv @@
`timescale 1ns / 1ps

module cfd_step import cfd_pkg::*; #(
	parameter int MAX_FRAME_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_in,
	input  logic        last_in,
	input  logic [7:0]  delimiter,
	output cfd_result_t result
);

	// Position counts up to and holds at the frame limit.
	localparam int POS_W = $clog2(MAX_FRAME_LEN + 1);
	// A code position can reach one short of the limit plus a full code byte.
	localparam int NCP_W = $clog2(MAX_FRAME_LEN + 255);

	logic [POS_W-1:0] byte_position_q;
	logic [NCP_W-1:0] next_code_q;
	logic             chain_ended_q;
	logic             too_long_q;

	logic [POS_W-1:0] byte_position_d;
	logic [NCP_W-1:0] next_code_d;
	logic             chain_ended_d;
	logic             too_long_d;
	logic             ended_here;
	logic [7:0]       data_out;
	logic             at_code;

	assign at_code = (NCP_W'(byte_position_q) == next_code_q);

	// Decode one word against the running frame state.
	always_comb begin
		byte_position_d = byte_position_q;
		next_code_d     = next_code_q;
		chain_ended_d   = chain_ended_q;
		too_long_d      = too_long_q;
		ended_here      = 1'b0;
		data_out        = data_in;
		if (too_long_q || (byte_position_q >= POS_W'(MAX_FRAME_LEN))) begin
			too_long_d = 1'b1;
		end else begin
			if (byte_position_q == '0) begin
				next_code_d = NCP_W'(data_in);
				if (data_in == 8'd0) begin
					chain_ended_d = 1'b1;
				end
			end else if (!chain_ended_q && at_code) begin
				if (data_in != 8'd0) begin
					data_out    = delimiter;
					next_code_d = next_code_q + NCP_W'(data_in);
				end else begin
					chain_ended_d = 1'b1;
					ended_here    = 1'b1;
				end
			end
			byte_position_d = byte_position_q + POS_W'(1);
		end
		// The last word of a frame returns the state to its reset values.
		if (last_in) begin
			byte_position_d = '0;
			next_code_d     = '0;
			chain_ended_d   = 1'b0;
			too_long_d      = 1'b0;
		end
	end

	assign result.data = data_out;
	assign result.last = last_in;
	assign result.ok   = last_in && ended_here;

	// Frame state advances once per decoded word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			next_code_q     <= '0;
			chain_ended_q   <= 1'b0;
			too_long_q      <= 1'b0;
		end else if (step) begin
			byte_position_q <= byte_position_d;
			next_code_q     <= next_code_d;
			chain_ended_q   <= chain_ended_d;
			too_long_q      <= too_long_d;
		end
	end

endmodule
